@@ sv/kps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types and constants of the matrix keypad scanner.
// ----------------------------------------------------------------------------
package kps_pkg;

  localparam int unsigned ROW_COUNT = 4;
  localparam int unsigned COL_COUNT = 4;

  localparam int unsigned CNT_W     = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 10;
  localparam int unsigned IN_W      = 16;
  localparam int unsigned OUT_W     = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET    = 2'd3;

  // Reset values of the registers
  localparam logic [7:0]       DEBOUNCE_RST = 8'd10;
  localparam logic [7:0]       SETTLE_RST   = 8'd1;
  localparam logic [CNT_W-1:0] RELEASE_RST  = 10'd500;
  localparam logic [7:0]       QUIET_RST    = 8'd10;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_SETTLE   = 3'd2,
    PH_RELEASE  = 3'd3,
    PH_QUIET    = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0]       debounce_ticks;
    logic [7:0]       settle_ticks;
    logic [CNT_W-1:0] release_timeout;
    logic [7:0]       quiet_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0] row_levels;
    logic [3:0] col_levels;
    logic       ir_owns_row1;
  } tick_t;

  typedef struct packed {
    logic       key_valid;
    logic [1:0] key_row;
    logic [1:0] key_col;
    logic       cols_driven_low;
    logic       row_driven_low;
    logic [1:0] driven_row;
  } result_t;

endpackage

@@ sv/kps_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_cfg_regs
// Timing registers of the keypad scanner, written through the config port.
// ----------------------------------------------------------------------------
module kps_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [kps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kps_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  output kps_pkg::cfg_t                  cfg_o
);

  kps_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index and take the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kps_pkg::REG_DEBOUNCE: cfg_d.debounce_ticks  = cfg_data_i[7:0];
        kps_pkg::REG_SETTLE:   cfg_d.settle_ticks    = cfg_data_i[7:0];
        kps_pkg::REG_RELEASE:  cfg_d.release_timeout = cfg_data_i;
        kps_pkg::REG_QUIET:    cfg_d.quiet_ticks     = cfg_data_i[7:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks  <= kps_pkg::DEBOUNCE_RST;
      cfg_q.settle_ticks    <= kps_pkg::SETTLE_RST;
      cfg_q.release_timeout <= kps_pkg::RELEASE_RST;
      cfg_q.quiet_ticks     <= kps_pkg::QUIET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/kps_tick_logic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_tick_logic
// Row edge detection, pending slot and scan phase machine; one tick per
// advance, result computed in the same cycle.
// ----------------------------------------------------------------------------
module kps_tick_logic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  kps_pkg::tick_t    tick_i,
  input  kps_pkg::cfg_t     cfg_i,
  output kps_pkg::result_t  res_o
);

  localparam logic [3:0] ROW_MASK = 4'((1 << kps_pkg::ROW_COUNT) - 1);

  kps_pkg::phase_e             phase_q, phase_d;
  logic                        pend_flag_q, pend_flag_d;
  logic [1:0]                  pend_row_q, pend_row_d;
  logic [1:0]                  active_row_q, active_row_d;
  logic [kps_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [3:0]                  armed_q, armed_d;
  logic [3:0]                  prev_q, prev_d;

  logic [3:0]                  fall;
  logic [1:0]                  fall_idx;
  logic                        col_found;
  logic [1:0]                  col_idx;
  logic [kps_pkg::CNT_W-1:0]   cnt_inc;
  logic                        drv;

  // Falling edges on armed rows, suppressed while a row is being scanned
  always_comb begin
    fall = prev_q & ~tick_i.row_levels & armed_q & ROW_MASK;
    if (tick_i.ir_owns_row1) begin
      fall[1] = 1'b0;
    end
    if (phase_q == kps_pkg::PH_SETTLE) begin
      fall = '0;
    end
  end

  // Lowest edging row and lowest low column
  always_comb begin
    fall_idx  = '0;
    col_found = 1'b0;
    col_idx   = '0;
    for (int i = kps_pkg::ROW_COUNT - 1; i >= 0; i--) begin
      if (fall[i]) begin
        fall_idx = 2'(i);
      end
    end
    for (int j = kps_pkg::COL_COUNT - 1; j >= 0; j--) begin
      if (!tick_i.col_levels[j]) begin
        col_found = 1'b1;
        col_idx   = 2'(j);
      end
    end
  end

  assign cnt_inc = (cnt_q == kps_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;

  // Next state and result of one tick
  always_comb begin
    phase_d      = phase_q;
    pend_flag_d  = pend_flag_q;
    pend_row_d   = pend_row_q;
    active_row_d = active_row_q;
    cnt_d        = cnt_q;
    armed_d      = armed_q & ~fall;
    prev_d       = tick_i.row_levels;
    res_o        = '0;

    // Latch the lowest edge when the slot is free
    if ((fall != '0) && !pend_flag_q) begin
      pend_flag_d = 1'b1;
      pend_row_d  = fall_idx;
    end

    unique case (phase_q)
      kps_pkg::PH_DEBOUNCE: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= {2'b00, cfg_i.debounce_ticks}) begin
          phase_d = kps_pkg::PH_SETTLE;
          cnt_d   = '0;
        end
      end
      kps_pkg::PH_SETTLE: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= {2'b00, cfg_i.settle_ticks}) begin
          armed_d = ROW_MASK;
          cnt_d   = '0;
          if (col_found) begin
            res_o.key_valid = 1'b1;
            res_o.key_row   = active_row_q;
            res_o.key_col   = col_idx;
            phase_d         = kps_pkg::PH_RELEASE;
          end else begin
            phase_d = kps_pkg::PH_IDLE;
          end
        end
      end
      kps_pkg::PH_RELEASE: begin
        cnt_d = cnt_inc;
        if (tick_i.row_levels[active_row_q] || (cnt_inc >= cfg_i.release_timeout)) begin
          phase_d = kps_pkg::PH_QUIET;
          cnt_d   = '0;
        end
      end
      kps_pkg::PH_QUIET: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= {2'b00, cfg_i.quiet_ticks}) begin
          armed_d[active_row_q] = ROW_MASK[active_row_q];
          phase_d               = kps_pkg::PH_IDLE;
          cnt_d                 = '0;
        end
      end
      default: begin
        // Idle, and unused codes behave as idle
        phase_d = kps_pkg::PH_IDLE;
        if (pend_flag_d) begin
          active_row_d = pend_row_d;
          pend_flag_d  = 1'b0;
          cnt_d        = '0;
          phase_d      = kps_pkg::PH_DEBOUNCE;
        end
      end
    endcase

    drv                   = (phase_q == kps_pkg::PH_SETTLE) ||
                            (phase_d == kps_pkg::PH_SETTLE);
    res_o.cols_driven_low = ~drv;
    res_o.row_driven_low  = drv;
    res_o.driven_row      = drv ? active_row_d : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= kps_pkg::PH_IDLE;
      pend_flag_q  <= 1'b0;
      pend_row_q   <= '0;
      active_row_q <= '0;
      cnt_q        <= '0;
      armed_q      <= '1;
      prev_q       <= '1;
    end else if (advance_i) begin
      phase_q      <= phase_d;
      pend_flag_q  <= pend_flag_d;
      pend_row_q   <= pend_row_d;
      active_row_q <= active_row_d;
      cnt_q        <= cnt_d;
      armed_q      <= armed_d;
      prev_q       <= prev_d;
    end
  end

  // A reported key always leads into the release wait
  a_key_to_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res_o.key_valid |=> phase_q == kps_pkg::PH_RELEASE)
    else $error("key reported without entering release wait");

  // A key is only reported while its row is driven
  a_key_while_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.key_valid |-> res_o.row_driven_low && (res_o.driven_row == res_o.key_row))
    else $error("key reported while its row is not driven");

  // Tick state moves only with an item
  a_hold_without_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(phase_q) && $stable(cnt_q) && $stable(armed_q))
    else $error("tick state changed without an item");

  // Entering debounce always frees the pending slot first
  a_slot_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && (phase_q == kps_pkg::PH_IDLE) && pend_flag_q
    |=> phase_q == kps_pkg::PH_DEBOUNCE && !pend_flag_q)
    else $error("pending row not taken by idle scanner");

endmodule

@@ sv/matrix_keypad_scanner_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_core
// 4x4 matrix keypad scanner stepped by one sampled tick per item.
// ----------------------------------------------------------------------------
// Each input item is one millisecond tick with the sampled row and column
// pins; each tick gives exactly one result item with the key report and the
// pin drive for the next tick. The block takes one item per clock cycle
// while results are taken: the accepted tick sits in the input register
// while the single pass of tick logic computes its result, which is loaded
// into the result register once it has room. Back-pressure on the result
// side stalls the input side through the result register. Debounce, settle,
// release and quiet times are counted in ticks. The user must set them
// through the configuration port while the block is idle; it does not check.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input ticks: tdata = row_levels[3:0], col_levels[7:4], ir_owns_row1[8]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [kps_pkg::IN_W-1:0]       s_axis_tdata,
  // Results: tdata = key_valid[0], key_row[2:1], key_col[4:3],
  //          cols_driven_low[5], row_driven_low[6], driven_row[8:7]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [kps_pkg::OUT_W-1:0]      m_axis_tdata,
  // Configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kps_pkg::CFG_DAT_W-1:0]  cfg_data_i
);

  logic              in_valid_q, in_valid_d;
  kps_pkg::tick_t    in_q;
  logic              out_valid_q, out_valid_d;
  kps_pkg::result_t  out_q;
  kps_pkg::result_t  res;
  kps_pkg::cfg_t     cfg;
  logic              advance;
  logic              in_take;

  assign cfg_ready_o = 1'b1;

  kps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Move the held tick into the result register when it has room
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.row_levels   <= s_axis_tdata[3:0];
      in_q.col_levels   <= s_axis_tdata[7:4];
      in_q.ir_owns_row1 <= s_axis_tdata[8];
    end
  end

  kps_tick_logic u_tick (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .tick_i    (in_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_q.driven_row, out_q.row_driven_low,
                          out_q.cols_driven_low, out_q.key_col, out_q.key_row,
                          out_q.key_valid};

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the matrix keypad scanner core.
// ----------------------------------------------------------------------------
// Ticks of row and column pin levels are streamed into the core. A tick-level
// model in the bench predicts the key report and pin drive of every tick, and
// each result item is checked in order against it. The run covers a press at
// the reset timing, short directed cases, and random press sequences with
// noise under several timing settings, the slowest and fastest among them.
// It also covers random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 6;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  // row_levels[3:0], col_levels[7:4], ir_owns_row1[8]
  logic [kps_pkg::IN_W-1:0]      s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // key_valid[0], key_row[2:1], key_col[4:3], cols_driven_low[5],
  // row_driven_low[6], driven_row[8:7]
  logic [kps_pkg::OUT_W-1:0]     m_axis_tdata;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [kps_pkg::CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [kps_pkg::CFG_DAT_W-1:0] cfg_data_i    = '0;

  // Bench mirror of the scanner state and timing registers
  kps_pkg::cfg_t   timing;
  kps_pkg::phase_e scan_phase;
  logic            pend_valid;
  logic [1:0]      pend_row;
  logic [1:0]      active_row;
  logic [9:0]      tick_cnt;
  logic [3:0]      armed;
  logic [3:0]      prev_rows;

  kps_pkg::result_t expected_reports[$];
  int unsigned      mismatches      = 0;
  int unsigned      ticks_sent      = 0;
  int unsigned      key_reports     = 0;
  int unsigned      settings_loaded = 0;

  // Idling control and the one long output stall
  logic        no_idle   = 1'b0;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  matrix_keypad_scanner_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Advance the mirror by one tick and return the report it gives
  function automatic kps_pkg::result_t keypad_tick(input kps_pkg::tick_t t);
    kps_pkg::phase_e  start_ph;
    logic [3:0]       fall;
    logic             found;
    logic [1:0]       col;
    logic             drv;
    kps_pkg::result_t res;
    int               i;
    start_ph = scan_phase;
    res      = '0;
    found    = 1'b0;
    col      = 2'd0;

    // Falling edges on armed rows, none while a row is being driven
    if (start_ph != kps_pkg::PH_SETTLE) begin
      fall = prev_rows & ~t.row_levels & armed;
      if (t.ir_owns_row1) fall[1] = 1'b0;
      armed = armed & ~fall;
      if (fall != 4'd0 && !pend_valid) begin
        for (i = 3; i >= 0; i--) if (fall[i]) pend_row = 2'(i);
        pend_valid = 1'b1;
      end
    end
    prev_rows = t.row_levels;

    if (start_ph != kps_pkg::PH_IDLE && tick_cnt != kps_pkg::CNT_MAX)
      tick_cnt = tick_cnt + 10'd1;

    case (start_ph)
      kps_pkg::PH_DEBOUNCE: begin
        if (tick_cnt >= timing.debounce_ticks) begin
          scan_phase = kps_pkg::PH_SETTLE;
          tick_cnt   = '0;
        end
      end
      kps_pkg::PH_SETTLE: begin
        if (tick_cnt >= timing.settle_ticks) begin
          for (i = 3; i >= 0; i--) begin
            if (!t.col_levels[i]) begin
              found = 1'b1;
              col   = 2'(i);
            end
          end
          armed    = 4'hF;
          tick_cnt = '0;
          if (found) begin
            res.key_valid = 1'b1;
            res.key_row   = active_row;
            res.key_col   = col;
            scan_phase    = kps_pkg::PH_RELEASE;
          end else begin
            scan_phase = kps_pkg::PH_IDLE;
          end
        end
      end
      kps_pkg::PH_RELEASE: begin
        if (t.row_levels[active_row] || tick_cnt >= timing.release_timeout) begin
          scan_phase = kps_pkg::PH_QUIET;
          tick_cnt   = '0;
        end
      end
      kps_pkg::PH_QUIET: begin
        if (tick_cnt >= timing.quiet_ticks) begin
          armed[active_row] = 1'b1;
          scan_phase        = kps_pkg::PH_IDLE;
          tick_cnt          = '0;
        end
      end
      default: begin
        if (pend_valid) begin
          active_row = pend_row;
          pend_valid = 1'b0;
          tick_cnt   = '0;
          scan_phase = kps_pkg::PH_DEBOUNCE;
        end
      end
    endcase

    drv = (start_ph == kps_pkg::PH_SETTLE) || (scan_phase == kps_pkg::PH_SETTLE);
    res.cols_driven_low = !drv;
    res.row_driven_low  = drv;
    res.driven_row      = drv ? active_row : 2'd0;
    return res;
  endfunction

  // Offer one tick, with random idle cycles ahead of it unless no_idle is set
  task automatic send_tick(input logic [3:0] rows, input logic [3:0] cols, input logic ir);
    kps_pkg::tick_t t;
    t = '{row_levels: rows, col_levels: cols, ir_owns_row1: ir};
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 19) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, ir, cols, rows};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_reports.push_back(keypad_tick(t));
    ticks_sent++;
  endtask

  // Drop the input and wait for every outstanding report
  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Hold the write until the core takes it, then update the mirror
  task automatic write_reg(input logic [kps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kps_pkg::CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      kps_pkg::REG_DEBOUNCE: timing.debounce_ticks  = data[7:0];
      kps_pkg::REG_SETTLE:   timing.settle_ticks    = data[7:0];
      kps_pkg::REG_RELEASE:  timing.release_timeout = data;
      kps_pkg::REG_QUIET:    timing.quiet_ticks     = data[7:0];
      default: ;
    endcase
  endtask

  task automatic load_timing(input logic [9:0] dbc, input logic [9:0] stl,
                             input logic [9:0] rel, input logic [9:0] qt);
    wait_until_drained();
    write_reg(kps_pkg::REG_DEBOUNCE, dbc);
    write_reg(kps_pkg::REG_SETTLE, stl);
    write_reg(kps_pkg::REG_RELEASE, rel);
    write_reg(kps_pkg::REG_QUIET, qt);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    settings_loaded++;
  endtask

  // Mostly whole key presses with bounce and stray pins, the rest pin noise
  task automatic random_keypad_traffic(input int unsigned budget);
    int unsigned first, r, c, lead, hold, tail, k;
    logic [3:0]  rows, cols;
    first = ticks_sent;
    while (ticks_sent - first < budget) begin
      if ($urandom_range(0, 99) < 75) begin
        r    = $urandom_range(0, 3);
        c    = $urandom_range(0, 3);
        lead = $urandom_range(1, 4);
        tail = $urandom_range(1, 6);
        if ($urandom_range(0, 99) < 80)
          hold = timing.debounce_ticks + timing.settle_ticks + $urandom_range(2, 12);
        else
          hold = $urandom_range(1, 6);
        for (k = 0; k < lead; k++)
          send_tick(4'hF, 4'($urandom_range(0, 15)), $urandom_range(0, 99) < 15);
        for (k = 0; k < hold; k++) begin
          rows = ~(4'b0001 << r);
          if (k < 3 && $urandom_range(0, 99) < 10) rows = 4'hF;
          if ($urandom_range(0, 99) < 10) rows = rows & 4'($urandom_range(0, 15));
          cols = ~(4'b0001 << c);
          if ($urandom_range(0, 99) < 20) cols = 4'($urandom_range(0, 15));
          send_tick(rows, cols, $urandom_range(0, 99) < 15);
        end
        for (k = 0; k < tail; k++)
          send_tick(4'hF, 4'($urandom_range(0, 15)), $urandom_range(0, 99) < 15);
      end else begin
        lead = $urandom_range(1, 8);
        for (k = 0; k < lead; k++)
          send_tick(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Press row 2, column 3 through the reset debounce and settle times
  task automatic test_reset_values();
    int k;
    for (k = 0; k < 12; k++) send_tick(4'hB, 4'h7, 1'b0);
    send_tick(4'hF, 4'hF, 1'b0);
  endtask

  // IR ownership, coincident edges, empty scan, timeout, all pins low
  task automatic test_special_cases();
    int k;
    load_timing(10'd0, 10'h301, 10'd1, 10'd0);
    send_tick(4'hF, 4'hF, 1'b0);
    send_tick(4'hD, 4'hF, 1'b1);
    send_tick(4'hF, 4'hF, 1'b1);
    for (k = 0; k < 4; k++) send_tick(4'h3, 4'hE, 1'b0);
    send_tick(4'hF, 4'hF, 1'b0);
    for (k = 0; k < 3; k++) send_tick(4'hE, 4'hF, 1'b0);
    for (k = 0; k < 4; k++) send_tick(4'h7, 4'h0, 1'b0);
    send_tick(4'h0, 4'h7, 1'b1);
    send_tick(4'hF, 4'h7, 1'b1);
    send_tick(4'hF, 4'h7, 1'b1);
    send_tick(4'hF, 4'hF, 1'b0);
    send_tick(4'hF, 4'hF, 1'b0);
  endtask

  task automatic test_fast_timing();
    load_timing(10'd0, 10'd1, 10'd1, 10'd0);
    no_idle <= 1'b1;
    random_keypad_traffic(50);
    wait_until_drained();
    no_idle <= 1'b0;
  endtask

  task automatic test_typical_timing();
    int k;
    for (k = 0; k < 2; k++) begin
      load_timing(10'($urandom_range(1, 6)), 10'($urandom_range(1, 4)),
                  10'($urandom_range(5, 40)), 10'($urandom_range(0, 6)));
      random_keypad_traffic(50);
    end
  endtask

  // Keep offering ticks while the output side stalls for a long stretch
  task automatic test_backpressure();
    hold_req <= 1'b1;
    random_keypad_traffic(60);
  endtask

  task automatic test_slowest_timing();
    load_timing(10'd255, 10'd255, 10'd1023, 10'd255);
    random_keypad_traffic(300);
  endtask

  // Output ready: random idling, or the long stall when requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= LONG_HOLD;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 19);
    end
  end

  // Compare each report with the oldest prediction
  always @(posedge clk_i) begin
    kps_pkg::result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.key_valid       = m_axis_tdata[0];
      got.key_row         = m_axis_tdata[2:1];
      got.key_col         = m_axis_tdata[4:3];
      got.cols_driven_low = m_axis_tdata[5];
      got.row_driven_low  = m_axis_tdata[6];
      got.driven_row      = m_axis_tdata[8:7];
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: report with no tick pending: %p", $realtime, got);
      end else begin
        want = expected_reports.pop_front();
        if (got.key_valid) key_reports++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: report mismatch", $realtime);
            $display("  expected kv=%b row=%0d col=%0d cdl=%b rdl=%b drow=%0d",
                     want.key_valid, want.key_row, want.key_col,
                     want.cols_driven_low, want.row_driven_low, want.driven_row);
            $display("  actual   kv=%b row=%0d col=%0d cdl=%b rdl=%b drow=%0d",
                     got.key_valid, got.key_row, got.key_col,
                     got.cols_driven_low, got.row_driven_low, got.driven_row);
          end
        end
      end
    end
  end

  initial begin
    timing     = '{kps_pkg::DEBOUNCE_RST, kps_pkg::SETTLE_RST,
                   kps_pkg::RELEASE_RST, kps_pkg::QUIET_RST};
    scan_phase = kps_pkg::PH_IDLE;
    pend_valid = 1'b0;
    pend_row   = 2'd0;
    active_row = 2'd0;
    tick_cnt   = '0;
    armed      = 4'hF;
    prev_rows  = 4'hF;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_special_cases();
    test_fast_timing();
    test_typical_timing();
    test_backpressure();
    test_slowest_timing();
    wait_until_drained();

    mismatches += expected_reports.size();
    $display("Sent %0d ticks under %0d timing settings besides reset; %0d key reports seen.",
             ticks_sent, settings_loaded, key_reports);
    $display("Stimulus included IR-owned row edges, coincident edges, empty scans, timeouts"
             , " and a %0d-cycle output stall.", LONG_HOLD);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit
  initial begin
    #200000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
sv/kps_pkg.sv
sv/kps_cfg_regs.sv
sv/kps_tick_logic.sv
sv/matrix_keypad_scanner_core.sv
dv/tb.sv
